// ===== design/ssmc_pkg.sv =====
// Shared constants, types and command/status structs for the subset sum counter.
package ssmc_pkg;

    localparam int MAX_MODULUS = 256;
    localparam int ADDR_W      = $clog2(MAX_MODULUS);
    localparam int MOD_W       = $clog2(MAX_MODULUS + 1);
    localparam int SIZE_W      = 12;
    localparam int MODIN_W     = 9;
    localparam int COUNT_W     = 64;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic load;      // capture request, start first pass
        logic issue;     // read one residue pair, advance index
        logic pass_end;  // swap banks, advance shift, count pass
        logic out_load;  // move result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic size_zero;
        logic idx_last;
        logic pass_last;
    } ctrl_stat_t;

endpackage

// ===== design/ssmc_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module ssmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== design/ssmc_datapath.sv =====
// Datapath: ping-pong residue tables, rotate-and-add pipeline, counters, result registers.
module ssmc_datapath import ssmc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output ctrl_stat_t         stat,
    input  logic [SIZE_W-1:0]  set_size,
    input  logic [MODIN_W-1:0] modulus,
    output logic [COUNT_W-1:0] subset_count
);

    logic [MOD_W-1:0]   mod_reg, mod_next, mod_in;
    logic [SIZE_W-1:0]  pass_left_reg, pass_left_next;
    logic [ADDR_W-1:0]  shift_reg, shift_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               sel_reg, sel_next;
    logic               first_reg, first_next;
    logic [MOD_W-1:0]   idx_w, shf_w, src_w, shf_inc;
    logic [ADDR_W-1:0]  src_addr;

    logic               s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]  s1_addr_reg, s1_src_reg;
    logic               s1_first_reg, s1_sel_reg;

    logic [COUNT_W-1:0] rd_a [2];
    logic [COUNT_W-1:0] rd_b [2];
    logic [COUNT_W-1:0] op_a, op_b, sum;
    logic [COUNT_W-1:0] result_reg, result_next;
    logic [COUNT_W-1:0] out_reg, out_next;

    // Clamp the requested modulus into 1..MAX_MODULUS
    always_comb
    begin
        if (modulus == '0)
        begin
            mod_in = MOD_W'(1);
        end
        else if (32'(modulus) > 32'(MAX_MODULUS))
        begin
            mod_in = MOD_W'(MAX_MODULUS);
        end
        else
        begin
            mod_in = MOD_W'(modulus);
        end
    end

    // Source residue of the rotation: (idx - shift) mod d
    always_comb
    begin
        idx_w = MOD_W'(idx_reg);
        shf_w = MOD_W'(shift_reg);
        if (idx_w >= shf_w)
        begin
            src_w = idx_w - shf_w;
        end
        else
        begin
            src_w = idx_w + mod_reg - shf_w;
        end
        src_addr = src_w[ADDR_W-1:0];
        shf_inc  = shf_w + MOD_W'(1);
    end

    assign stat.size_zero = (set_size == '0);
    assign stat.idx_last  = (idx_w == mod_reg - MOD_W'(1));
    assign stat.pass_last = (pass_left_reg == SIZE_W'(1));

    always_comb
    begin
        mod_next       = mod_reg;
        pass_left_next = pass_left_reg;
        shift_next     = shift_reg;
        idx_next       = idx_reg;
        sel_next       = sel_reg;
        first_next     = first_reg;
        if (cmd.load)
        begin
            mod_next       = mod_in;
            pass_left_next = set_size;
            shift_next     = (mod_in == MOD_W'(1)) ? '0 : ADDR_W'(1);
            idx_next       = '0;
            sel_next       = 1'b0;
            first_next     = 1'b1;
        end
        else
        begin
            if (cmd.issue)
            begin
                idx_next = stat.idx_last ? '0 : idx_reg + ADDR_W'(1);
            end
            if (cmd.pass_end)
            begin
                pass_left_next = pass_left_reg - SIZE_W'(1);
                shift_next     = (shf_inc >= mod_reg) ? '0 : shf_inc[ADDR_W-1:0];
                sel_next       = ~sel_reg;
                first_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg       <= mod_next;
        pass_left_reg <= pass_left_next;
        shift_reg     <= shift_next;
        idx_reg       <= idx_next;
        sel_reg       <= sel_next;
        first_reg     <= first_next;
        s1_addr_reg   <= idx_reg;
        s1_src_reg    <= src_addr;
        s1_first_reg  <= first_reg;
        s1_sel_reg    <= sel_reg;
        result_reg    <= result_next;
        out_reg       <= out_next;
    end

    assign s1_valid_next = cmd.issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Both banks; a pass reads one and writes the other
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        ssmc_ram #(
            .WIDTH (COUNT_W),
            .DEPTH (MAX_MODULUS)
        ) u_ram (
            .clk       (clk),
            .wr_en     (s1_valid_reg && (s1_sel_reg != 1'(b))),
            .wr_addr   (s1_addr_reg),
            .wr_data   (sum),
            .rd_addr_a (idx_reg),
            .rd_data_a (rd_a[b]),
            .rd_addr_b (src_addr),
            .rd_data_b (rd_b[b])
        );
    end

    // First pass reads the initial table: one at residue zero, zero elsewhere
    always_comb
    begin
        if (s1_first_reg)
        begin
            op_a = (s1_addr_reg == '0) ? COUNT_W'(1) : '0;
            op_b = (s1_src_reg == '0) ? COUNT_W'(1) : '0;
        end
        else
        begin
            op_a = rd_a[s1_sel_reg];
            op_b = rd_b[s1_sel_reg];
        end
        sum = op_a + op_b;
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.load)
        begin
            result_next = COUNT_W'(1);
        end
        else if (s1_valid_reg && s1_addr_reg == '0)
        begin
            result_next = sum;
        end
        out_next = cmd.out_load ? result_reg : out_reg;
    end

    assign subset_count = out_reg;

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (MOD_W'(idx_reg) < mod_reg && src_w < mod_reg))
        else $error("residue index out of modulus range");

    a_issue_feeds_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> s1_valid_reg && s1_addr_reg == $past(idx_reg))
        else $error("issued read did not reach write stage");

endmodule

// ===== design/ssmc_ctrl.sv =====
// Controller: request sequencing state machine and output valid flag.
module ssmc_ctrl import ssmc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.size_zero ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last write of the pass lands here
                cmd.pass_end = 1'b1;
                state_next   = stat.pass_last ? ST_FINISH : ST_ISSUE;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_valid_reg && !out_ready |=> state_reg == ST_FINISH)
        else $error("result overwrote unread output");

endmodule

// ===== design/subset_sum_mod_counter.sv =====
// Top level of the subset sum modulo counter.
//
// Counts the subsets of {1..n} (empty set included) whose sum is divisible by d.
// Input channel in_valid/in_ready carries set_size (n) and modulus (d); a
// modulus of zero acts as one and one above 256 acts as 256. The output channel
// out_valid/out_ready carries subset_count, wrapped modulo 2^64, one per request.
// One request at a time: with d the clamped modulus, in_ready falls on the input
// transaction and rises again, together with out_valid, once the count is loaded
// into the output register (no pass is run for n = 0). Every element pass reads d
// residue pairs through the two read ports of the table memory, one residue per
// cycle, and then lets the last write of the pass land before the next pass or the
// load of the result.
// Two 256 x 64 tables alternate as source and destination between passes;
// the first pass reads the initial table implicitly, so no clearing is needed.
// The finished count sits in an output register, so a new transaction is taken
// while the result waits; if the receiver still stalls when the next count is
// done, the block holds that count and takes no further transaction.
// Reset clears the controller, the output valid flag and the pipeline valid bit; the tables need none.
module subset_sum_mod_counter import ssmc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SIZE_W-1:0]  set_size,
    input  logic [MODIN_W-1:0] modulus,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COUNT_W-1:0] subset_count
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    ssmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssmc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .set_size     (set_size),
        .modulus      (modulus),
        .subset_count (subset_count)
    );

endmodule

// ===== verif/subset_sum_mod_counter_test.sv =====
// Testbench for the subset sum modulo counter: directed and randomized requests checked against a predictor.
module subset_sum_mod_counter_test;
    import ssmc_pkg::*;

    localparam int IDLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_COUNT = 80;
    localparam int SETTLE       = 50;

    typedef struct {
        logic [SIZE_W-1:0]  req_size;
        logic [MODIN_W-1:0] req_mod;
        bit                 drain;
    } request_t;

    typedef struct {
        logic [SIZE_W-1:0]  req_size;
        logic [MODIN_W-1:0] req_mod;
        logic [COUNT_W-1:0] count;
    } awaited_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [SIZE_W-1:0]  set_size  = '0;
    logic [MODIN_W-1:0] modulus   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COUNT_W-1:0] subset_count;

    request_t pending_requests[$];
    awaited_t awaited_counts[$];

    int  error_count   = 0;
    int  results_seen  = 0;
    int  directed_count;
    bit  in_taken      = 1'b0;
    int  gap_left      = 0;
    int  burst_left    = 1;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    int  rx_phase_left = 0;
    int  idle_cycles   = 0;

    subset_sum_mod_counter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .set_size     (set_size),
        .modulus      (modulus),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .subset_count (subset_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Count of subsets of {1..n} with sum divisible by d, modulo 2^64.
    function automatic logic [COUNT_W-1:0] count_divisible_subsets(
        input logic [SIZE_W-1:0] n, input logic [MODIN_W-1:0] m);
        logic [COUNT_W-1:0] counts [MAX_MODULUS];
        logic [COUNT_W-1:0] rotated [MAX_MODULUS];
        int d;
        int shift;
        int t;
        d = int'(m);
        if (d == 0)
            d = 1;
        if (d > MAX_MODULUS)
            d = MAX_MODULUS;
        for (int r = 0; r < MAX_MODULUS; r++)
            counts[r] = '0;
        counts[0] = COUNT_W'(1);
        shift = 0;
        for (int v = 1; v <= int'(n); v++)
        begin
            shift++;
            if (shift >= d)
                shift = 0;
            for (int r = 0; r < d; r++)
                rotated[r] = '0;
            for (int r = 0; r < d; r++)
            begin
                t = r + shift;
                if (t >= d)
                    t -= d;
                rotated[t] += counts[r];
            end
            for (int r = 0; r < d; r++)
                counts[r] += rotated[r];
        end
        return counts[0];
    endfunction

    task automatic add_request(input int n, input int d, input bit drain);
        request_t req;
        req.req_size = SIZE_W'(n);
        req.req_mod  = MODIN_W'(d);
        req.drain    = drain;
        pending_requests.push_back(req);
    endtask

    // Sender: bursts of transactions with random gaps; optional drain before an item.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain && awaited_counts.size() != 0))
                begin
                    in_valid <= 1'b1;
                    set_size <= pending_requests[0].req_size;
                    modulus  <= pending_requests[0].req_mod;
                    pending_requests.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 10);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready pattern plus one long hold-off after the directed part.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen == directed_count)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (rx_phase_left > 0)
                rx_phase_left <= rx_phase_left - 1;
            else
            begin
                out_ready     <= ($urandom_range(0, 3) != 0);
                rx_phase_left <= $urandom_range(0, 20);
            end
        end
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge clk)
    begin
        awaited_t exp_item;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                exp_item.req_size = set_size;
                exp_item.req_mod  = modulus;
                exp_item.count    = count_divisible_subsets(set_size, modulus);
                awaited_counts.push_back(exp_item);
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_counts.size() == 0)
                begin
                    $display("%0t: unexpected subset_count: expected none, got %0d",
                             $time, subset_count);
                    error_count++;
                end
                else
                begin
                    exp_item = awaited_counts.pop_front();
                    if (subset_count !== exp_item.count)
                    begin
                        $display("%0t: subset_count mismatch n=%0d d=%0d: expected %0d, got %0d",
                                 $time, exp_item.req_size, exp_item.req_mod,
                                 exp_item.count, subset_count);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int n;
        int d;
        int pick;
        // directed: empty set, zero modulus, saturation, 2^64 wrap, bit extremes
        add_request(0, 0, 1'b0);
        add_request(0, 1, 1'b0);
        add_request(1, 0, 1'b0);
        add_request(1, 1, 1'b0);
        add_request(4095, 0, 1'b0);
        add_request(4095, 1, 1'b0);
        add_request(1, 256, 1'b0);
        add_request(3, 256, 1'b0);
        add_request(2, 511, 1'b0);
        add_request(5, 257, 1'b0);
        add_request(20, 300, 1'b0);
        add_request(4095, 2, 1'b0);
        add_request(63, 1, 1'b0);
        add_request(64, 1, 1'b0);
        add_request(65, 0, 1'b0);
        add_request(2048, 3, 1'b0);
        add_request(10, 10, 1'b0);
        add_request(7, 3, 1'b0);
        add_request(100, 7, 1'b0);
        add_request(12, 255, 1'b0);
        add_request(30, 256, 1'b0);
        add_request(4095, 4, 1'b0);
        directed_count = pending_requests.size();

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            pick = $urandom_range(0, 9);
            if (i < 12)
            begin
                // tiny requests so the long hold-off backs the block up
                n = $urandom_range(0, 4);
                d = $urandom_range(0, 4);
            end
            else if (pick == 0)
            begin
                n = $urandom_range(0, 4095);
                d = $urandom_range(0, 3);
            end
            else if (pick == 1)
            begin
                n = $urandom_range(0, 12);
                d = $urandom_range(0, 511);
            end
            else
            begin
                n = $urandom_range(0, 40);
                d = $urandom_range(0, 40);
            end
            add_request(n, d, (i == 0) || (i == 60));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() != 0 || in_valid || awaited_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
